// ===== rtl/symbol_address_lookup_unit_macros.svh =====
// Assertion helpers used by salu_ctrl.sv; clk and arst_n are taken from the scope of use.
`ifndef SYMBOL_ADDRESS_LOOKUP_UNIT_MACROS_SVH
`define SYMBOL_ADDRESS_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication
`define SALU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SALU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/salu_pkg.sv =====
// ---------------------------------------------------------------------------
// salu_pkg
// Shared constants, codes and controller/datapath bundles for the symbol
// address lookup unit.
// ---------------------------------------------------------------------------
package salu_pkg;

	localparam int MAX_SYMBOLS = 1024;
	localparam int IDX_W = $clog2(MAX_SYMBOLS);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_NAME_OOR = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_NOT_FOUND,
		RES_FULL,
		RES_HIT
	} res_kind_t;

	typedef struct packed {
		logic      append;
		logic      clear;
		logic      addr_load;
		logic      srch_init;
		logic      srch_use_order;
		logic      rd_order;
		logic      rd_entry;
		logic      bound_update;
		logic      build_init;
		logic      scan;
		logic      pass_end;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic sorted_empty;
		logic range_empty;
		logic use_order;
		logic hit;
		logic scan_done;
		logic best_valid;
	} dp_sts_t;

endpackage

// ===== rtl/salu_dpath.sv =====
// ---------------------------------------------------------------------------
// salu_dpath
// Entry and order memories, search bounds, sort scan registers and the
// result registers.
// ---------------------------------------------------------------------------
module salu_dpath
	import salu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dcmd,
	output dp_sts_t             dsts,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic [63:0]         sym_value,
	input  logic [31:0]         sym_size,
	input  logic [15:0]         sym_section,
	input  logic [7:0]          sym_info,
	input  logic [31:0]         sym_name,
	input  logic [63:0]         lookup_addr,
	output logic [1:0]          status,
	output logic [63:0]         addr_offset,
	output logic [31:0]         name_offset
);

	logic [63:0]      start_mem [MAX_SYMBOLS];
	logic [31:0]      len_mem   [MAX_SYMBOLS];
	logic [31:0]      name_mem  [MAX_SYMBOLS];
	logic             fn_mem    [MAX_SYMBOLS];
	logic [IDX_W-1:0] order_mem [MAX_SYMBOLS];

	logic [CNT_W-1:0] entry_cnt_q, sorted_cnt_q;
	logic [31:0]      stsize_q;
	logic [63:0]      addr_q;
	logic [CNT_W-1:0] first_q, last_q, cur;
	logic             use_order_q;
	logic [IDX_W-1:0] ord_rd_q;
	logic [63:0]      start_rd_q;
	logic [31:0]      len_rd_q, name_rd_q;
	logic             fn_rd_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic [CNT_W-1:0] scan_i_q, out_cnt_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pend_idx_s1;
	logic             best_valid_q, prev_valid_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [63:0]      best_start_q, prev_start_q;
	logic             cand;

	logic [1:0]       res_status_q;
	logic [63:0]      res_offset_q;
	logic [31:0]      res_name_q;

	logic             fn_new;
	logic             lt_lo, below_hi;

	assign cur    = first_q + ((last_q - first_q) >> 1);
	assign fn_new = (sym_section != 16'd0) && (sym_info[3:0] == 4'd2);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur[IDX_W-1:0];
		if (dcmd.rd_entry) begin
			rd_en   = 1'b1;
			rd_addr = use_order_q ? ord_rd_q : cur[IDX_W-1:0];
		end else if (dcmd.scan && scan_i_q < entry_cnt_q) begin
			rd_en   = 1'b1;
			rd_addr = scan_i_q[IDX_W-1:0];
		end
	end

	// entry memories: one write port (append), one read port
	always_ff @(posedge clk) begin
		if (dcmd.append && !dsts.full) begin
			start_mem[entry_cnt_q[IDX_W-1:0]] <= sym_value;
			len_mem[entry_cnt_q[IDX_W-1:0]]   <= fn_new ? sym_size : 32'd0;
			name_mem[entry_cnt_q[IDX_W-1:0]]  <= sym_name;
			fn_mem[entry_cnt_q[IDX_W-1:0]]    <= fn_new;
		end
		if (rd_en) begin
			start_rd_q <= start_mem[rd_addr];
			len_rd_q   <= len_mem[rd_addr];
			name_rd_q  <= name_mem[rd_addr];
			fn_rd_q    <= fn_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.pass_end && best_valid_q)
			order_mem[out_cnt_q[IDX_W-1:0]] <= best_idx_q;
		if (dcmd.rd_order)
			ord_rd_q <= order_mem[cur[IDX_W-1:0]];
	end

	assign lt_lo    = addr_q < start_rd_q;
	assign below_hi = addr_q < (start_rd_q + {32'd0, len_rd_q});

	// candidate for the next sorted position: smallest start above the last one taken
	assign cand = pend_s1 && fn_rd_q
		&& (!prev_valid_q || start_rd_q > prev_start_q)
		&& (!best_valid_q || start_rd_q < best_start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q  <= '0;
			sorted_cnt_q <= '0;
			stsize_q     <= '0;
			pend_s1      <= 1'b0;
			use_order_q  <= 1'b0;
			best_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				stsize_q <= cfg_wdata;
			if (dcmd.append && !dsts.full) begin
				entry_cnt_q  <= entry_cnt_q + 1'b1;
				sorted_cnt_q <= '0;
			end
			if (dcmd.clear) begin
				entry_cnt_q  <= '0;
				sorted_cnt_q <= '0;
			end
			if (dcmd.srch_init)
				use_order_q <= dcmd.srch_use_order;
			pend_s1 <= dcmd.scan && (scan_i_q < entry_cnt_q);
			if (dcmd.build_init) begin
				best_valid_q <= 1'b0;
				prev_valid_q <= 1'b0;
			end
			if (cand)
				best_valid_q <= 1'b1;
			if (dcmd.pass_end) begin
				best_valid_q <= 1'b0;
				if (best_valid_q)
					prev_valid_q <= 1'b1;
				else
					sorted_cnt_q <= out_cnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.addr_load)
			addr_q <= lookup_addr;
		if (dcmd.srch_init) begin
			first_q <= '0;
			// the last pass hands its count over directly
			if (dcmd.pass_end)
				last_q <= out_cnt_q;
			else
				last_q <= dcmd.srch_use_order ? sorted_cnt_q : entry_cnt_q;
		end
		if (dcmd.bound_update) begin
			if (lt_lo)
				last_q <= cur;
			else
				first_q <= cur + 1'b1;
		end
		if (dcmd.build_init) begin
			scan_i_q  <= '0;
			out_cnt_q <= '0;
		end
		if (dcmd.scan && scan_i_q < entry_cnt_q) begin
			scan_i_q    <= scan_i_q + 1'b1;
			pend_idx_s1 <= scan_i_q[IDX_W-1:0];
		end
		if (cand) begin
			best_idx_q   <= pend_idx_s1;
			best_start_q <= start_rd_q;
		end
		if (dcmd.pass_end) begin
			scan_i_q <= '0;
			if (best_valid_q) begin
				out_cnt_q    <= out_cnt_q + 1'b1;
				prev_start_q <= best_start_q;
			end
		end
		if (dcmd.res_load) begin
			res_offset_q <= 64'd0;
			res_name_q   <= 32'd0;
			case (dcmd.res_kind)
				RES_NOT_FOUND: res_status_q <= ST_MISS;
				RES_FULL:      res_status_q <= ST_FULL;
				RES_HIT: begin
					res_offset_q <= addr_q - start_rd_q;
					res_name_q   <= name_rd_q;
					res_status_q <= (name_rd_q < stsize_q) ? ST_OK : ST_NAME_OOR;
				end
				default:       res_status_q <= ST_OK;
			endcase
		end
		if (dcmd.out_load) begin
			status      <= res_status_q;
			addr_offset <= res_offset_q;
			name_offset <= res_name_q;
		end
	end

	always_comb begin
		dsts.full         = entry_cnt_q == CNT_W'(MAX_SYMBOLS);
		dsts.sorted_empty = sorted_cnt_q == '0;
		dsts.range_empty  = first_q >= last_q;
		dsts.use_order    = use_order_q;
		dsts.hit          = !lt_lo && below_hi;
		dsts.scan_done    = (scan_i_q >= entry_cnt_q) && !pend_s1;
		dsts.best_valid   = best_valid_q;
	end

endmodule

// ===== rtl/salu_ctrl.sv =====
// ---------------------------------------------------------------------------
// salu_ctrl
// Sequencer for appends, clears, lookups (a search, and on a miss with no
// sorted order the order build and a second search) and the output beat.
// ---------------------------------------------------------------------------
`include "symbol_address_lookup_unit_macros.svh"

module salu_ctrl
	import salu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    dcmd,
	input  dp_sts_t    dsts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RDORD,
		S_RDENT,
		S_CMP,
		S_SCAN,
		S_PASS,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   accept;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;
		dcmd        = '0;
		dcmd.res_kind = RES_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_FINISH;
					dcmd.res_load = 1'b1;
					case (cmd)
						CMD_APPEND: begin
							dcmd.append   = 1'b1;
							dcmd.res_kind = dsts.full ? RES_FULL : RES_ZERO;
						end
						CMD_CLEAR: dcmd.clear = 1'b1;
						CMD_LOOKUP: begin
							dcmd.res_load       = 1'b0;
							dcmd.addr_load      = 1'b1;
							dcmd.srch_init      = 1'b1;
							dcmd.srch_use_order = !dsts.sorted_empty;
							state_d             = S_CHECK;
						end
						default: ;
					endcase
				end
			end
			S_CHECK: begin
				if (!dsts.range_empty)
					state_d = dsts.use_order ? S_RDORD : S_RDENT;
				else if (!dsts.use_order) begin
					dcmd.build_init = 1'b1;
					state_d         = S_SCAN;
				end else begin
					dcmd.res_load = 1'b1;
					dcmd.res_kind = RES_NOT_FOUND;
					state_d       = S_FINISH;
				end
			end
			S_RDORD: begin
				dcmd.rd_order = 1'b1;
				state_d       = S_RDENT;
			end
			S_RDENT: begin
				dcmd.rd_entry = 1'b1;
				state_d       = S_CMP;
			end
			S_CMP: begin
				if (dsts.hit) begin
					dcmd.res_load = 1'b1;
					dcmd.res_kind = RES_HIT;
					state_d       = S_FINISH;
				end else begin
					dcmd.bound_update = 1'b1;
					state_d           = S_CHECK;
				end
			end
			S_SCAN: begin
				if (dsts.scan_done)
					state_d = S_PASS;
				else
					dcmd.scan = 1'b1;
			end
			S_PASS: begin
				dcmd.pass_end = 1'b1;
				if (dsts.best_valid)
					state_d = S_SCAN;
				else begin
					// order complete: search it
					dcmd.srch_init      = 1'b1;
					dcmd.srch_use_order = 1'b1;
					state_d             = S_CHECK;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					dcmd.out_load = 1'b1;
					out_valid_d   = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	`SALU_ASSERT_NOW(a_out_free, dcmd.out_load, !out_valid_q || !out_stall, "output overwritten")
	`SALU_ASSERT_NXT(a_busy_after, accept, in_stall, "accepted while busy")
	`SALU_ASSERT_NOW(a_ord_rd, dcmd.rd_order, dsts.use_order, "order read in load-order search")

endmodule

// ===== rtl/symbol_address_lookup_unit.sv =====
// ---------------------------------------------------------------------------
// symbol_address_lookup_unit
// Symbol table with address-to-function lookup.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one command beat: append entry,
// look up address, or clear. Output channel (out_valid/out_stall) returns
// one result beat per command. cfg_we/cfg_wdata write the string table size.
// Append, clear and unused commands: the finish state loads the result into
// the output register. Lookup: a binary search of about log2(N)+1 steps,
// each a range check, a sorted-order read when searching through the order,
// an entry read on the single read port of the entry memory and a compare.
// A miss with no sorted order builds it by a selection scan, one pass over
// all entries per distinct function address plus a final empty pass, then
// searches the order. Later lookups use it directly until an append or clear.
// One command is worked at a time; in_stall is high until its result is
// in the output register. A stalled result holds; the next command is still
// taken while it waits. Reset empties the table and the order and clears
// the string table size; memory contents need no clearing.
// ---------------------------------------------------------------------------
module symbol_address_lookup_unit
	import salu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] sym_value,
	input  logic [31:0] sym_size,
	input  logic [15:0] sym_section,
	input  logic [7:0]  sym_info,
	input  logic [31:0] sym_name,
	input  logic [63:0] lookup_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] addr_offset,
	output logic [31:0] name_offset
);

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	salu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dcmd      (dcmd),
		.dsts      (dsts)
	);

	salu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.dsts        (dsts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.sym_value   (sym_value),
		.sym_size    (sym_size),
		.sym_section (sym_section),
		.sym_info    (sym_info),
		.sym_name    (sym_name),
		.lookup_addr (lookup_addr),
		.status      (status),
		.addr_offset (addr_offset),
		.name_offset (name_offset)
	);

endmodule
